/* rtl/lbfgsu_pkg.sv */
// Package for the global shape update block: sizes, command codes, the result
// record type, address mapping and saturating arithmetic helpers.
// Depends on nothing; used by lbf_global_shape_update_top and its testbench.
`default_nettype none

package lbfgsu_pkg;

  // Model dimensions.
  localparam int LANDMARKS  = 68;
  localparam int DEPTH      = 5;
  localparam int TREES      = 16;

  localparam int ROWS       = 2 * LANDMARKS;
  localparam int LEAVES     = 1 << DEPTH;
  localparam int COLS       = TREES * LEAVES;
  localparam int MEM_DEPTH  = LANDMARKS * COLS;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int COL_W      = $clog2(COLS);
  localparam int LM_W       = 7;

  // Command codes carried by the cmd field.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_ACCUM = 1'b1;

  // Result queue sizing. CREDIT_W holds 0..FIFO_DEPTH.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    logic [LM_W-1:0] lm;
    q16_t            pos_x;
    q16_t            pos_y;
    q16_t            delta_x;
    q16_t            delta_y;
  } result_t;

  // Flat address of a landmark's weight in a per-axis weight memory.
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [LM_W-1:0] lm,
                                                 input logic [COL_W-1:0] col);
    mem_addr = ADDR_W'(lm) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

  // Signed add clamped to 32 bits.
  function automatic q16_t sat_add(input q16_t a, input q16_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // Signed subtract a - b clamped to 32 bits.
  function automatic q16_t sat_sub(input q16_t a, input q16_t b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    if (s[32] != s[31]) begin
      sat_sub = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_sub = s[31:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/lbf_global_shape_update_top.sv */
// Top level of the global shape update block: weight memories, accumulator
// pipeline and result queue.
// Depends on lbfgsu_pkg.
`default_nettype none

// The block takes one beat per clock cycle while in_stall is low, weight
// writes and leaf accumulations alike, and a run of accumulations for one
// landmark may come back to back. Weights live in two synchronous memories
// (x rows and y rows), each 68 x 512 words, with no reset and no clearing
// pass; every weight must be written before it is used. A result passes the
// stage 1 and stage 2 registers into a four-entry queue whose head drives the
// output; the input stalls only while four results are in flight or queued,
// so a full queue is what limits the input rate when the output stalls.
module lbf_global_shape_update_top (
  input  wire                                 clk,
  input  wire                                 rst,
  // Input channel.
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 cmd,
  input  wire  [7:0]                          weight_row,
  input  wire  [8:0]                          weight_col,
  input  wire  signed [31:0]                  weight_value,
  input  wire  [6:0]                          landmark,
  input  wire  [3:0]                          tree,
  input  wire  [4:0]                          leaf,
  input  wire  signed [31:0]                  start_x,
  input  wire  signed [31:0]                  start_y,
  input  wire  signed [31:0]                  target_x,
  input  wire  signed [31:0]                  target_y,
  input  wire                                 last_tree,
  // Output channel.
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [6:0]                          out_landmark,
  output logic signed [31:0]                  pos_x,
  output logic signed [31:0]                  pos_y,
  output logic signed [31:0]                  delta_x,
  output logic signed [31:0]                  delta_y
);

  // Weight memories, one per axis.
  lbfgsu_pkg::q16_t mem_x [lbfgsu_pkg::MEM_DEPTH];
  lbfgsu_pkg::q16_t mem_y [lbfgsu_pkg::MEM_DEPTH];

  logic                              in_accept;
  logic                              wr_ok;
  logic                              acc_ok;
  logic [lbfgsu_pkg::COL_W-1:0]      wr_col;
  logic [lbfgsu_pkg::COL_W-1:0]      rd_col;
  logic [lbfgsu_pkg::ADDR_W-1:0]     wr_addr;
  logic [lbfgsu_pkg::ADDR_W-1:0]     rd_addr;

  // Stage 1: read data and the item that asked for it.
  logic                              s1_valid;
  logic                              s1_tree0;
  logic                              s1_last;
  logic [lbfgsu_pkg::LM_W-1:0]       s1_lm;
  lbfgsu_pkg::q16_t                  s1_start_x, s1_start_y;
  lbfgsu_pkg::q16_t                  s1_target_x, s1_target_y;
  lbfgsu_pkg::q16_t                  rd_x, rd_y;

  // Running accumulators.
  lbfgsu_pkg::q16_t                  acc_x, acc_y;
  lbfgsu_pkg::q16_t                  acc_x_next, acc_y_next;
  lbfgsu_pkg::q16_t                  base_x, base_y;

  // Stage 2: finished position waiting for the delta.
  logic                              s2_valid;
  logic [lbfgsu_pkg::LM_W-1:0]       s2_lm;
  lbfgsu_pkg::q16_t                  s2_pos_x, s2_pos_y;
  lbfgsu_pkg::q16_t                  s2_target_x, s2_target_y;
  lbfgsu_pkg::result_t               s2_result;

  // Result queue and credit count.
  lbfgsu_pkg::result_t               fifo [lbfgsu_pkg::FIFO_DEPTH];
  logic [lbfgsu_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [lbfgsu_pkg::CREDIT_W-1:0]   fifo_count;
  logic [lbfgsu_pkg::CREDIT_W-1:0]   credit;
  logic                              out_accept;
  logic                              credit_inc;
  lbfgsu_pkg::result_t               head;

  // Decode the incoming beat and its range checks.
  assign in_accept = in_valid && !in_stall;
  assign wr_col    = lbfgsu_pkg::COL_W'(weight_col);
  assign rd_col    = (lbfgsu_pkg::COL_W'(tree) << lbfgsu_pkg::DEPTH) |
                     lbfgsu_pkg::COL_W'(leaf);
  assign wr_addr   = lbfgsu_pkg::mem_addr(weight_row[7:1], wr_col);
  assign rd_addr   = lbfgsu_pkg::mem_addr(landmark, rd_col);

  assign wr_ok  = (cmd == lbfgsu_pkg::CMD_WRITE) &&
                  (int'(weight_row) < lbfgsu_pkg::ROWS) &&
                  (int'(weight_col) < lbfgsu_pkg::COLS);
  assign acc_ok = (cmd == lbfgsu_pkg::CMD_ACCUM) &&
                  (int'(landmark) < lbfgsu_pkg::LANDMARKS) &&
                  (int'(tree) < lbfgsu_pkg::TREES) &&
                  (int'(leaf) < lbfgsu_pkg::LEAVES);

  // Weight writes. The row's low bit picks the axis.
  always_ff @(posedge clk) begin
    if (in_accept && wr_ok && !weight_row[0]) begin
      mem_x[wr_addr] <= weight_value;
    end
    if (in_accept && wr_ok && weight_row[0]) begin
      mem_y[wr_addr] <= weight_value;
    end
  end

  // Weight reads with registered data. A write lands at the edge that accepts
  // it, before any later beat reads, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (in_accept && acc_ok) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (in_accept && acc_ok) begin
      s1_tree0    <= (tree == 4'd0);
      s1_last     <= last_tree;
      s1_lm       <= landmark;
      s1_start_x  <= start_x;
      s1_start_y  <= start_y;
      s1_target_x <= target_x;
      s1_target_y <= target_y;
    end
  end

  // Accumulate: tree 0 restarts from the start position.
  always_comb begin
    base_x     = s1_tree0 ? s1_start_x : acc_x;
    base_y     = s1_tree0 ? s1_start_y : acc_y;
    acc_x_next = lbfgsu_pkg::sat_add(base_x, rd_x);
    acc_y_next = lbfgsu_pkg::sat_add(base_y, rd_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (s1_valid) begin
      acc_x <= acc_x_next;
      acc_y <= acc_y_next;
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_last) begin
      s2_lm       <= s1_lm;
      s2_pos_x    <= acc_x_next;
      s2_pos_y    <= acc_y_next;
      s2_target_x <= s1_target_x;
      s2_target_y <= s1_target_y;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept && acc_ok;
      s2_valid <= s1_valid && s1_last;
    end
  end

  // Delta to the target, formed on the way into the queue.
  always_comb begin
    s2_result.lm      = s2_lm;
    s2_result.pos_x   = s2_pos_x;
    s2_result.pos_y   = s2_pos_y;
    s2_result.delta_x = lbfgsu_pkg::sat_sub(s2_target_x, s2_pos_x);
    s2_result.delta_y = lbfgsu_pkg::sat_sub(s2_target_y, s2_pos_y);
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fifo[wr_ptr] <= s2_result;
    end
  end

  // Queue pointers and occupancy.
  assign out_accept = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_accept) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({s2_valid, out_accept})
        2'b10:   fifo_count <= fifo_count + 1'b1;
        2'b01:   fifo_count <= fifo_count - 1'b1;
        default: fifo_count <= fifo_count;
      endcase
    end
  end

  // Credits cover results in the pipeline plus those queued, so the queue
  // can never overflow.
  assign credit_inc = in_accept && acc_ok && last_tree;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      unique case ({credit_inc, out_accept})
        2'b10:   credit <= credit + 1'b1;
        2'b01:   credit <= credit - 1'b1;
        default: credit <= credit;
      endcase
    end
  end

  assign in_stall = (credit >= lbfgsu_pkg::CREDIT_W'(lbfgsu_pkg::FIFO_DEPTH));

  // Output beat comes straight from the queue head.
  assign head         = fifo[rd_ptr];
  assign out_valid    = (fifo_count != '0);
  assign out_landmark = head.lm;
  assign pos_x        = head.pos_x;
  assign pos_y        = head.pos_y;
  assign delta_x      = head.delta_x;
  assign delta_y      = head.delta_y;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for lbf_global_shape_update_top: a table of directed beats,
// then random weight loads and leaf accumulation runs, checked against a local predictor.
// Depends on lbfgsu_pkg and the block's RTL.
module tb;
  import lbfgsu_pkg::*;

  localparam int     LIVE_TARGET  = 1900;
  localparam int     DEAD_LIMIT   = 5000;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     HOLD_AT      = 20;
  localparam int     DRAIN_CYCLES = 12;
  localparam longint Q_MAX        = 64'sd2147483647;
  localparam longint Q_MIN        = -64'sd2147483648;

  // One input beat, field by field.
  typedef struct {
    logic       cmd;
    logic [7:0] weight_row;
    logic [8:0] weight_col;
    q16_t       weight_value;
    logic [6:0] landmark;
    logic [3:0] tree;
    logic [4:0] leaf;
    q16_t       start_x;
    q16_t       start_y;
    q16_t       target_x;
    q16_t       target_y;
    logic       last_tree;
  } beat_t;

  // A row of the directed table, with an optional result typed in by hand.
  typedef struct {
    beat_t   b;
    bit      has_want;
    result_t want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd = 1'b0;
  logic [7:0] weight_row = '0;
  logic [8:0] weight_col = '0;
  q16_t       weight_value = '0;
  logic [6:0] landmark = '0;
  logic [3:0] tree = '0;
  logic [4:0] leaf = '0;
  q16_t       start_x = '0;
  q16_t       start_y = '0;
  q16_t       target_x = '0;
  q16_t       target_y = '0;
  logic       last_tree = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_landmark;
  q16_t       pos_x;
  q16_t       pos_y;
  q16_t       delta_x;
  q16_t       delta_y;

  // Predictor state: its own weight store, written flags and accumulators.
  q16_t    weight_mem [ROWS][COLS];
  bit      weight_set [ROWS][COLS];
  q16_t    track_x = '0;
  q16_t    track_y = '0;
  result_t shape_q[$];
  int      n_fail = 0;
  int      n_live = 0;
  bit      calm = 1'b0;
  int      dead_cnt = 0;

  always #5 clk = ~clk;

  lbf_global_shape_update_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .weight_row   (weight_row),
    .weight_col   (weight_col),
    .weight_value (weight_value),
    .landmark     (landmark),
    .tree         (tree),
    .leaf         (leaf),
    .start_x      (start_x),
    .start_y      (start_y),
    .target_x     (target_x),
    .target_y     (target_y),
    .last_tree    (last_tree),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_landmark (out_landmark),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .delta_x      (delta_x),
    .delta_y      (delta_y)
  );

  // Clamp a wide sum to the signed 32-bit range.
  function automatic q16_t clamp_q16(input longint v);
    if (v > Q_MAX) return 32'h7FFF_FFFF;
    if (v < Q_MIN) return 32'h8000_0000;
    return q16_t'(v);
  endfunction

  // Apply one accepted beat to the predictor; returns 1 when it yields a result.
  function automatic bit predict_shape(input beat_t b, output result_t r);
    int   col;
    q16_t wx;
    q16_t wy;
    r = '0;
    if (b.cmd == CMD_WRITE) begin
      if (b.weight_row < ROWS && b.weight_col < COLS) begin
        weight_mem[b.weight_row][b.weight_col] = b.weight_value;
        weight_set[b.weight_row][b.weight_col] = 1'b1;
      end
      return 1'b0;
    end
    if (b.landmark >= LANDMARKS || b.tree >= TREES || b.leaf >= LEAVES) return 1'b0;
    col = b.tree * LEAVES + b.leaf;
    wx = weight_mem[2 * b.landmark][col];
    wy = weight_mem[2 * b.landmark + 1][col];
    // Tree zero restarts from the start position.
    if (b.tree == 0) begin
      track_x = b.start_x;
      track_y = b.start_y;
    end
    track_x = clamp_q16(longint'(track_x) + longint'(wx));
    track_y = clamp_q16(longint'(track_y) + longint'(wy));
    if (!b.last_tree) return 1'b0;
    r.lm      = b.landmark;
    r.pos_x   = track_x;
    r.pos_y   = track_y;
    r.delta_x = clamp_q16(longint'(b.target_x) - longint'(track_x));
    r.delta_y = clamp_q16(longint'(b.target_y) - longint'(track_y));
    return 1'b1;
  endfunction

  function automatic beat_t junk_beat();
    beat_t b;
    b.cmd          = 1'($urandom);
    b.weight_row   = 8'($urandom);
    b.weight_col   = 9'($urandom);
    b.weight_value = $urandom;
    b.landmark     = 7'($urandom);
    b.tree         = 4'($urandom);
    b.leaf         = 5'($urandom);
    b.start_x      = $urandom;
    b.start_y      = $urandom;
    b.target_x     = $urandom;
    b.target_y     = $urandom;
    b.last_tree    = 1'($urandom);
    return b;
  endfunction

  // Positions: extremes now and then, small moves, or anything.
  function automatic q16_t pick_pos();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return q16_t'($signed(24'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  // Weights are mostly small so that runs do not stay pinned at the rails.
  function automatic q16_t pick_weight();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return q16_t'($signed(20'($urandom)));
    endcase
  endfunction

  function automatic logic [6:0] pick_lm();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'(LANDMARKS - 1);
      default: return 7'($urandom_range(LANDMARKS - 1));
    endcase
  endfunction

  function automatic row_t mk_write(input int row, input int col, input q16_t v);
    row_t r;
    r.b = '{cmd: CMD_WRITE, weight_row: 8'(row), weight_col: 9'(col), weight_value: v,
            landmark: '0, tree: '0, leaf: '0, start_x: '0, start_y: '0,
            target_x: '0, target_y: '0, last_tree: 1'b1};
    r.has_want = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t mk_leaf(input int lm, input int t, input int lf,
                                   input q16_t sx, input q16_t sy,
                                   input q16_t tx, input q16_t ty, input bit last);
    row_t r;
    r.b = '{cmd: CMD_ACCUM, weight_row: '0, weight_col: '0, weight_value: '0,
            landmark: 7'(lm), tree: 4'(t), leaf: 5'(lf), start_x: sx, start_y: sy,
            target_x: tx, target_y: ty, last_tree: last};
    r.has_want = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t with_want(input row_t r, input int lm, input q16_t px,
                                     input q16_t py, input q16_t dx, input q16_t dy);
    row_t o;
    o = r;
    o.has_want = 1'b1;
    o.want = '{lm: 7'(lm), pos_x: px, pos_y: py, delta_x: dx, delta_y: dy};
    return o;
  endfunction

  // Offer one beat, idling at random first, and record what it should produce.
  task automatic send_beat(input beat_t b, input bit has_want = 1'b0,
                           input result_t want = '0);
    result_t r;
    bit      made;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd          <= b.cmd;
    weight_row   <= b.weight_row;
    weight_col   <= b.weight_col;
    weight_value <= b.weight_value;
    landmark     <= b.landmark;
    tree         <= b.tree;
    leaf         <= b.leaf;
    start_x      <= b.start_x;
    start_y      <= b.start_y;
    target_x     <= b.target_x;
    target_y     <= b.target_y;
    last_tree    <= b.last_tree;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    made = predict_shape(b, r);
    if (made) shape_q.push_back(has_want ? want : r);
    if ((b.cmd == CMD_WRITE && b.weight_row < ROWS) ||
        (b.cmd == CMD_ACCUM && b.landmark < LANDMARKS)) n_live++;
  endtask

  task automatic issue_write(input int row, input int col, input q16_t v);
    beat_t b;
    b = junk_beat();
    b.cmd          = CMD_WRITE;
    b.weight_row   = 8'(row);
    b.weight_col   = 9'(col);
    b.weight_value = v;
    send_beat(b);
  endtask

  // One leaf beat; both weights it reads are loaded first if still unwritten,
  // and sometimes reloaded right before the read.
  task automatic issue_leaf(input logic [6:0] lm, input int t, input bit last);
    beat_t b;
    int    lf;
    int    col;
    lf = $urandom_range(LEAVES - 1);
    col = t * LEAVES + lf;
    for (int ax = 0; ax < 2; ax++) begin
      if (!weight_set[2 * lm + ax][col] || $urandom_range(99) < 15)
        issue_write(2 * lm + ax, col, pick_weight());
    end
    b = junk_beat();
    b.cmd       = CMD_ACCUM;
    b.landmark  = lm;
    b.tree      = 4'(t);
    b.leaf      = 5'(lf);
    b.last_tree = last;
    b.start_x   = pick_pos();
    b.start_y   = pick_pos();
    b.target_x  = pick_pos();
    b.target_y  = pick_pos();
    send_beat(b);
  endtask

  // A run of trees for one landmark. A broken run starts at any tree, may switch
  // landmark, and raises or drops the last-tree flag anywhere.
  task automatic run_sequence(input bit broken);
    logic [6:0] lm;
    int         t_lo;
    int         t_hi;
    lm = pick_lm();
    if (broken) begin
      t_lo = $urandom_range(TREES - 1);
      t_hi = $urandom_range(TREES - 1, t_lo);
    end else begin
      t_lo = 0;
      t_hi = $urandom_range(1) ? $urandom_range(3) : $urandom_range(TREES - 1);
    end
    for (int t = t_lo; t <= t_hi; t++) begin
      if (broken && $urandom_range(1)) lm = pick_lm();
      issue_leaf(lm, t, broken ? ($urandom_range(99) < 40) : (t == t_hi));
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      n_fail++;
    end
  endtask

  // Stimulus: reset, directed table, then random traffic.
  initial begin : stim
    row_t  plan[$];
    beat_t b;
    int    pick;
    bit    paused;
    paused = 1'b0;

    // Rail values, ignored writes, ignored landmarks, restart on tree zero,
    // saturating adds and deltas, and a write read back on the next beat.
    plan.push_back(mk_write(0, 0, 32'h7FFF_FFFF));
    plan.push_back(mk_write(1, 0, 32'h8000_0000));
    plan.push_back(mk_write(ROWS - 2, COLS - 1, 32'hFFFF_FFFF));
    plan.push_back(mk_write(ROWS - 1, COLS - 1, 32'h0001_0000));
    plan.push_back(mk_write(ROWS, 0, 32'h0000_0005));
    plan.push_back(mk_write(255, COLS - 1, 32'h1234_5678));
    plan.push_back(with_want(mk_leaf(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h8000_0000, 32'h7FFF_FFFF, 1'b1),
                             0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(with_want(mk_leaf(LANDMARKS - 1, TREES - 1, LEAVES - 1, '0, '0, '0, '0,
                                     1'b1),
                             LANDMARKS - 1, 32'h7FFF_FFFE, 32'h8001_0000,
                             32'h8000_0002, 32'h7FFF_0000));
    plan.push_back(mk_leaf(127, 0, 0, 32'h1, 32'h1, '0, '0, 1'b1));
    plan.push_back(mk_leaf(LANDMARKS, 3, 5, '0, '0, '0, '0, 1'b1));
    plan.push_back(mk_write(0, 0, '0));
    plan.push_back(mk_write(1, 0, '0));
    plan.push_back(with_want(mk_leaf(0, 0, 0, 32'h1234_0000, 32'hFFFF_FFFB,
                                     32'h1234_0000, 32'hFFFF_FFFB, 1'b1),
                             0, 32'h1234_0000, 32'hFFFF_FFFB, '0, '0));
    plan.push_back(mk_leaf(0, 0, 0, 32'h1, 32'h2, '0, '0, 1'b0));
    plan.push_back(mk_write(2, LEAVES + 1, 32'h0002_0000));
    plan.push_back(mk_write(3, LEAVES + 1, 32'hFFFE_0000));
    plan.push_back(mk_leaf(1, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 1'b0));
    plan.push_back(mk_write(ROWS - 2, 0, 32'h8000_0000));
    plan.push_back(mk_write(ROWS - 1, 0, 32'h7FFF_FFFF));
    plan.push_back(mk_leaf(LANDMARKS - 1, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 1'b0));
    plan.push_back(with_want(mk_leaf(LANDMARKS - 1, TREES - 1, LEAVES - 1, '0, '0,
                                     32'h7FFF_FFFF, 32'h8000_0000, 1'b1),
                             LANDMARKS - 1, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(mk_leaf(1, 1, 1, '0, '0, 32'h0005_0000, '0, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i].b, plan[i].has_want, plan[i].want);

    // Random part: mostly well-formed runs, some broken runs, noise and reloads.
    while (n_live < LIVE_TARGET) begin
      calm = (n_live >= 600 && n_live < 900);
      if (!paused && n_live >= 1200) begin
        // Sender goes quiet until every pending result has been taken.
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (shape_q.size() != 0);
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_sequence(1'b0);
      end else if (pick < 80) begin
        run_sequence(1'b1);
      end else if (pick < 90) begin
        if ($urandom_range(1)) begin
          issue_write($urandom_range(255, ROWS), $urandom_range(COLS - 1), $urandom);
        end else begin
          b = junk_beat();
          b.cmd = CMD_ACCUM;
          b.landmark = 7'($urandom_range(127, LANDMARKS));
          send_beat(b);
        end
      end else begin
        issue_write($urandom_range(ROWS - 1), $urandom_range(COLS - 1), pick_weight());
      end
    end
    calm = 1'b0;

    // Drain, then give the pipeline time to show any stray result.
    in_valid <= 1'b0;
    do @(posedge clk); while (shape_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("lbf_global_shape_update_top verification clean");
    end else begin
      $display("lbf_global_shape_update_top verification failed");
    end
    $finish;
  end

  // Result side: check each accepted beat, drive random stall, and hold off
  // once for a long stretch so that the result queue fills.
  initial begin : result_side
    result_t want;
    int      n_got;
    int      hold_left;
    n_got = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        n_got++;
        if (shape_q.size() == 0) begin
          $error("result for landmark %0d arrived with nothing expected", out_landmark);
          n_fail++;
        end else begin
          want = shape_q.pop_front();
          cmp_field("out_landmark", 32'(want.lm), 32'(out_landmark));
          cmp_field("pos_x", want.pos_x, pos_x);
          cmp_field("pos_y", want.pos_y, pos_y);
          cmp_field("delta_x", want.delta_x, delta_x);
          cmp_field("delta_y", want.delta_y, delta_y);
        end
        if (n_got == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!calm && $urandom_range(99) < 31);
      end
    end
  end

  // Watchdog: too many cycles with no beat on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dead_cnt <= 0;
    end else begin
      dead_cnt <= dead_cnt + 1;
      if (dead_cnt >= DEAD_LIMIT) begin
        $display("lbf_global_shape_update_top verification failed");
        $finish;
      end
    end
  end

endmodule
